FILE: hw/rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = COLUMNS * ROWS;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned SWEEP_W = $clog2(CELL_COUNT + 1);

  localparam logic [CELL_W-1:0] ATTR_MASK    = 16'hFF00;
  localparam logic [CHAR_W-1:0] NUL_CODE     = 8'h00;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] char_code;
    logic [ADDR_W-1:0] cell_addr;
  } in_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_data;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              screen_cleared;
  } out_word_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tcw_if.sv
`default_nettype none

interface tcw_in_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] char_code;
  logic [ADDR_W-1:0] cell_addr;

  modport source (output valid, output cmd, output char_code, output cell_addr, input ready);
  modport sink   (input valid, input cmd, input char_code, input cell_addr, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;

  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_data;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic              screen_cleared;

  modport source (output valid, output cell_data, output cursor_col, output cursor_row,
                  output screen_cleared, input ready);
  modport sink   (input valid, input cell_data, input cursor_col, input cursor_row,
                  input screen_cleared, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tcw_cell_ram.sv
`default_nettype none

module tcw_cell_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 8,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  tcw_in_if.sink                      cmd_i,
  input  wire logic                   slot_free_i,
  output logic                        res_load_o,
  output tcw_pkg::out_word_t          res_o,
  output tcw_pkg::ram_req_t           ram_req_o,
  input  wire logic [tcw_pkg::CELL_W-1:0] ram_rdata_i
);
  import tcw_pkg::*;

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RMW    = 5'b00100,
    S_SWEEP  = 5'b01000,
    S_RESULT = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [SWEEP_W-1:0] sw_q, sw_d;
  in_word_t           item_q, item_d;
  out_word_t          res_q, res_d;

  logic [COL_W-1:0]   col_inc;
  logic [ROW_W-1:0]   row_inc;
  logic [COL_W-1:0]   col_n;
  logic [ROW_W-1:0]   row_n;
  logic [ADDR_W-1:0]  idx_n;
  logic               clear;

  assign col_inc = col_q + COL_W'(1);
  assign row_inc = row_q + ROW_W'(1);

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    idx_d      = idx_q;
    sw_d       = sw_q;
    item_d     = item_q;
    res_d      = res_q;
    res_load_o = 1'b0;
    ram_req_o  = '0;
    cmd_i.ready = 1'b0;
    col_n      = col_q;
    row_n      = row_q;
    idx_n      = idx_q;
    clear      = 1'b0;

    unique case (state_q)
      S_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = sw_q[ADDR_W-1:0];
        if (sw_q == SWEEP_W'(CELL_COUNT - 1)) begin
          sw_d    = '0;
          state_d = S_IDLE;
        end else begin
          sw_d = sw_q + SWEEP_W'(1);
        end
      end

      S_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.cmd == CMD_READ) begin
          if (cmd_i.cell_addr < ADDR_W'(CELL_COUNT)) begin
            ram_req_o.raddr = cmd_i.cell_addr;
          end
        end else begin
          ram_req_o.raddr = idx_q;
        end
        if (cmd_i.valid) begin
          item_d.cmd       = cmd_i.cmd;
          item_d.char_code = cmd_i.char_code;
          item_d.cell_addr = cmd_i.cell_addr;
          state_d          = S_RMW;
        end
      end

      S_RMW: begin
        res_d = '0;
        if (item_q.cmd == CMD_READ) begin
          if (item_q.cell_addr < ADDR_W'(CELL_COUNT)) begin
            res_d.cell_data = ram_rdata_i;
          end
        end else if (item_q.char_code != NUL_CODE) begin
          if (item_q.char_code == NEWLINE_CODE) begin
            col_n = '0;
            row_n = row_inc;
            idx_n = idx_q - ADDR_W'(col_q) + ADDR_W'(COLUMNS);
          end else begin
            ram_req_o.we    = 1'b1;
            ram_req_o.waddr = idx_q;
            ram_req_o.wdata = (ram_rdata_i & ATTR_MASK) | {{(CELL_W-CHAR_W){1'b0}},
                                                           item_q.char_code};
            idx_n = idx_q + ADDR_W'(1);
            if (col_inc >= COL_W'(COLUMNS)) begin
              col_n = '0;
              row_n = row_inc;
            end else begin
              col_n = col_inc;
            end
          end
          if (row_n >= ROW_W'(ROWS)) begin
            clear = 1'b1;
            col_n = '0;
            row_n = '0;
            idx_n = '0;
          end
        end
        col_d                = col_n;
        row_d                = row_n;
        idx_d                = idx_n;
        res_d.cursor_col     = col_n;
        res_d.cursor_row     = row_n;
        res_d.screen_cleared = clear;
        if (clear) begin
          sw_d    = '0;
          state_d = S_SWEEP;
        end else if (slot_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end else begin
          state_d = S_RESULT;
        end
      end

      S_SWEEP: begin
        if (sw_q < SWEEP_W'(CELL_COUNT)) begin
          ram_req_o.raddr = sw_q[ADDR_W-1:0];
        end
        if (sw_q != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = ADDR_W'(sw_q - SWEEP_W'(1));
          ram_req_o.wdata = (ram_rdata_i & ATTR_MASK) | {{(CELL_W-CHAR_W){1'b0}}, SPACE_CODE};
        end
        if (sw_q == SWEEP_W'(CELL_COUNT)) begin
          sw_d    = '0;
          state_d = S_RESULT;
        end else begin
          sw_d = sw_q + SWEEP_W'(1);
        end
      end

      S_RESULT: begin
        if (slot_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        sw_d    = '0;
        state_d = S_INIT;
      end
    endcase
  end

  assign res_o = res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      col_q   <= '0;
      row_q   <= '0;
      idx_q   <= '0;
      sw_q    <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      idx_q   <= idx_d;
      sw_q    <= sw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/text_console_writer_unit.sv
// Channel  Role    Word
// cmd_i    sink    cmd, char_code, cell_addr
// res_o    source  cell_data, cursor_col, cursor_row, screen_cleared
//
// A read or put reads the cell memory as the word is taken; a put of any code but NUL or
// newline then modifies the cell and writes it back. A put that scrolls past the last row
// adds a blanking pass over every cell, through the single read and single write port of
// the cell memory, before its result is issued. After reset a clearing pass zeroes every
// cell of the memory; no word is taken meanwhile. A held result sits in the output
// register while the next word is taken.
`default_nettype none

module text_console_writer_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tcw_in_if.sink    cmd_i,
  tcw_out_if.source res_o
);
  import tcw_pkg::*;

  logic              slot_free;
  logic              res_load;
  out_word_t         res_word;
  ram_req_t          ram_req;
  logic [CELL_W-1:0] ram_rdata;
  logic              out_valid_q;
  out_word_t         out_word_q;
  logic              in_acc;

  assign slot_free = !out_valid_q || res_o.ready;
  assign in_acc    = cmd_i.valid && cmd_i.ready;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .slot_free_i (slot_free),
    .res_load_o  (res_load),
    .res_o       (res_word),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  tcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_word_q <= res_word;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.cell_data      = out_word_q.cell_data;
  assign res_o.cursor_col     = out_word_q.cursor_col;
  assign res_o.cursor_row     = out_word_q.cursor_row;
  assign res_o.screen_cleared = out_word_q.screen_cleared;

`ifndef SYNTH
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> slot_free)
    else $error("result loaded into a full output register");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !cmd_i.ready)
    else $error("word taken while the previous one is in flight");

  a_read_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cmd_i.cmd == CMD_READ |=> res_load || !slot_free)
    else $error("read result not issued on the following cycle");

  a_clear_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_o.screen_cleared |-> res_o.cursor_col == '0 && res_o.cursor_row == '0)
    else $error("cleared screen without homed cursor");
`endif

endmodule

`default_nettype wire

FILE: dv/text_console_writer_unit_tb.sv
`timescale 1ns / 1ps

module text_console_writer_unit_tb;
  import tcw_pkg::*;

  localparam int unsigned RAND_WORDS = 1850;
  localparam int unsigned DIR_N      = 23;
  localparam int unsigned DIR_W      = $clog2(DIR_N);

  typedef struct packed {
    logic      typed;
    in_word_t  w;
    out_word_t e;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tcw_in_if  cmd_if ();
  tcw_out_if res_if ();

  text_console_writer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if.sink),
    .res_o  (res_if.source)
  );

  always #10 clk_i = ~clk_i;

  logic [CELL_W-1:0] screen_mem [CELL_COUNT];
  int unsigned       cur_col;
  int unsigned       cur_row;
  out_word_t         console_replies_q [$];
  int unsigned       err_count;
  int unsigned       word_count;
  int unsigned       src_idle_pct;
  int unsigned       snk_idle_pct;
  int unsigned       rx_hold_len;

  dir_row_t dir_tbl [DIR_N] = '{
    {1'b1, CMD_READ, 8'h00,        11'd0,    16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_READ, 8'h00,        11'h7FF,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_READ, 8'h00,        11'd1999, 16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  NUL_CODE,     11'd5,    16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  8'h41,        11'd0,    16'h0000, 7'd1, 5'd0, 1'b0},
    {1'b1, CMD_READ, 8'h00,        11'd0,    16'h0041, 7'd1, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  8'hFF,        11'd0,    16'h0000, 7'd2, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  8'h01,        11'd0,    16'h0000, 7'd3, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  NEWLINE_CODE, 11'd0,    16'h0000, 7'd0, 5'd1, 1'b0},
    {1'b0, CMD_READ, 8'h00,        11'd1,    16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_READ, 8'h00,        11'd2,    16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_READ, 8'h00,        11'd2000, 16'h0000, 7'd0, 5'd1, 1'b0},
    {1'b0, CMD_PUT,  8'h80,        11'h400,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_PUT,  8'h7F,        11'h3FF,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_PUT,  8'h55,        11'h555,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_PUT,  8'hAA,        11'h2AA,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b1, CMD_PUT,  NUL_CODE,     11'h7FF,  16'h0000, 7'd4, 5'd1, 1'b0},
    {1'b0, CMD_READ, 8'h00,        11'd80,   16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_READ, 8'h00,        11'd83,   16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_READ, 8'h00,        11'd1024, 16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_READ, 8'hFF,        11'd84,   16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_PUT,  NEWLINE_CODE, 11'h7FF,  16'h0000, 7'd0, 5'd0, 1'b0},
    {1'b0, CMD_PUT,  SPACE_CODE,   11'd0,    16'h0000, 7'd0, 5'd0, 1'b0}
  };

  function automatic out_word_t console_step(in_word_t w);
    out_word_t   r;
    int unsigned idx;
    int unsigned k;
    r = '0;
    if (w.cmd == CMD_READ) begin
      if (w.cell_addr < ADDR_W'(CELL_COUNT)) r.cell_data = screen_mem[w.cell_addr];
    end else if (w.char_code != NUL_CODE) begin
      if (w.char_code == NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        idx = cur_row * COLUMNS + cur_col;
        if (idx < CELL_COUNT) begin
          screen_mem[ADDR_W'(idx)] = {screen_mem[ADDR_W'(idx)][CELL_W-1:CHAR_W], w.char_code};
        end
        cur_col++;
      end
      if (cur_col >= COLUMNS) begin
        cur_col = 0;
        cur_row++;
      end
      if (cur_row >= ROWS) begin
        for (k = 0; k < CELL_COUNT; k++) begin
          screen_mem[ADDR_W'(k)] = (screen_mem[ADDR_W'(k)] & ATTR_MASK) |
                                   {{(CELL_W-CHAR_W){1'b0}}, SPACE_CODE};
        end
        cur_col = 0;
        cur_row = 0;
        r.screen_cleared = 1'b1;
      end
    end
    r.cursor_col = cur_col[COL_W-1:0];
    r.cursor_row = cur_row[ROW_W-1:0];
    return r;
  endfunction

  task automatic send_word(in_word_t w, logic typed, out_word_t fixed);
    out_word_t p;
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid     <= 1'b1;
    cmd_if.cmd       <= w.cmd;
    cmd_if.char_code <= w.char_code;
    cmd_if.cell_addr <= w.cell_addr;
    do @(posedge clk_i); while (!cmd_if.ready);
    p = console_step(w);
    console_replies_q.push_back(typed ? fixed : p);
    if (!(w.cmd == CMD_PUT && w.char_code == NUL_CODE)) word_count++;
  endtask

  function automatic logic [ADDR_W-1:0] near_cursor();
    int unsigned a;
    a = (cur_row * COLUMNS + cur_col + CELL_COUNT - $urandom_range(1, 4)) % CELL_COUNT;
    return a[ADDR_W-1:0];
  endfunction

  task automatic run_segment();
    int unsigned kind;
    int unsigned len;
    int unsigned pick;
    int unsigned i;
    in_word_t    w;
    kind = $urandom_range(99);
    if (kind < 40) len = 20;
    else if (kind < 60) len = $urandom_range(60, 170);
    else if (kind < 80) len = $urandom_range(5, 30);
    else len = $urandom_range(10, 30);
    for (i = 0; i < len; i++) begin
      w.cmd       = CMD_PUT;
      w.char_code = CHAR_W'($urandom_range(1, 255));
      w.cell_addr = ADDR_W'($urandom_range(2047));
      pick = $urandom_range(99);
      if (kind < 40) begin
        if (pick < 15) w.char_code = NEWLINE_CODE;
        else if (pick < 20) w.char_code = NUL_CODE;
        else if (pick < 40) begin
          w.cmd       = CMD_READ;
          w.cell_addr = near_cursor();
        end else if (pick < 50) w.cmd = CMD_READ;
      end else if (kind < 60) begin
        // long line: wrap at the row end
        if (pick < 10) begin
          w.cmd       = CMD_READ;
          w.cell_addr = near_cursor();
        end else if (w.char_code == NEWLINE_CODE) w.char_code = SPACE_CODE;
      end else if (kind < 80) w.char_code = NEWLINE_CODE;
      else w.cmd = CMD_READ;
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, logic [CELL_W-1:0] exp_v, logic [CELL_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endtask

  initial begin
    out_word_t e;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        if (console_replies_q.size() == 0) begin
          $error("res_o: word with no expectation waiting");
          err_count++;
        end else begin
          e = console_replies_q.pop_front();
          check_field("cell_data", e.cell_data, res_if.cell_data);
          check_field("cursor_col", CELL_W'(e.cursor_col), CELL_W'(res_if.cursor_col));
          check_field("cursor_row", CELL_W'(e.cursor_row), CELL_W'(res_if.cursor_row));
          check_field("screen_cleared", CELL_W'(e.screen_cleared),
                      CELL_W'(res_if.screen_cleared));
        end
      end
    end
  end

  initial begin
    int unsigned n;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        n = rx_hold_len;
        rx_hold_len = 0;
        res_if.ready <= 1'b0;
        repeat (n) @(negedge clk_i);
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned i;
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.cmd       = CMD_PUT;
    cmd_if.char_code = NUL_CODE;
    cmd_if.cell_addr = '0;
    res_if.ready     = 1'b0;
    err_count        = 0;
    word_count       = 0;
    src_idle_pct     = 37;
    snk_idle_pct     = 37;
    rx_hold_len      = 0;
    cur_col          = 0;
    cur_row          = 0;
    for (i = 0; i < CELL_COUNT; i++) screen_mem[ADDR_W'(i)] = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIR_N; i++) begin
      send_word(dir_tbl[DIR_W'(i)].w, dir_tbl[DIR_W'(i)].typed, dir_tbl[DIR_W'(i)].e);
    end

    // hold the sender until the block has drained
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (console_replies_q.size() != 0) @(posedge clk_i);

    word_count = 0;
    while (word_count < 600) run_segment();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    while (word_count < 1000) run_segment();
    src_idle_pct = 37;
    snk_idle_pct = 37;
    rx_hold_len  = 400;
    while (word_count < 1300) run_segment();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (console_replies_q.size() != 0) @(posedge clk_i);
    while (word_count < RAND_WORDS) run_segment();

    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    while (console_replies_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_if.sv
hw/rtl/tcw_cell_ram.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/text_console_writer_unit.sv
dv/text_console_writer_unit_tb.sv
